>>> hdl/assert_macros.svh
// Assertion helpers for the checker file.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Opcodes, job codes and the job word passed from decoder to memory engine.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam logic [7:0] OPC_WREN  = 8'h06;
  localparam logic [7:0] OPC_WRDI  = 8'h04;
  localparam logic [7:0] OPC_READ  = 8'h03;
  localparam logic [7:0] OPC_WRITE = 8'h02;

  // What the memory engine does for one word.
  localparam logic [1:0] JOB_NONE  = 2'd0;
  localparam logic [1:0] JOB_READ  = 2'd1;
  localparam logic [1:0] JOB_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } job_t;

endpackage

>>> hdl/sfs_front.sv
// ----------------------------------------------------------------------------
// sfs_front
// Frame decoder: tracks opcode/address phases, write-enable latch and the
// running address, and turns each accepted word into a memory job.
// ----------------------------------------------------------------------------
module sfs_front #(
  parameter int MEM_DEPTH = 8192,
  parameter int ADDR_W    = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              op,
  input  logic [7:0]        mosi_byte,
  output sfs_pkg::job_t     job,
  output logic [ADDR_W-1:0] job_addr
);
  import sfs_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_AHI    = 3'd1;
  localparam logic [2:0] PH_ALO    = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_IGNORE = 3'd4;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // (hi * 256) mod depth, folded at elaboration
  typedef logic [ADDR_W-1:0] hi_tab_t [256];

  function automatic hi_tab_t build_hi_tab();
    hi_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = ADDR_W'((i * 256) % MEM_DEPTH);
    end
    return t;
  endfunction

  localparam hi_tab_t HI_TAB = build_hi_tab();
  localparam logic [ADDR_W:0] DEPTH_EXT = (ADDR_W+1)'(MEM_DEPTH);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MEM_DEPTH - 1);

  logic [2:0]        phase, phase_next;
  logic [1:0]        cmd, cmd_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic [ADDR_W-1:0] hi_mod, hi_mod_next;
  logic              wel, wel_next;
  logic [ADDR_W:0]   addr_sum;

  assign addr_sum = {1'b0, hi_mod} + (ADDR_W+1)'(mosi_byte);

  always_comb begin
    phase_next  = phase;
    cmd_next    = cmd;
    addr_next   = addr;
    hi_mod_next = hi_mod;
    wel_next    = wel;
    job.kind    = JOB_NONE;
    job.data    = mosi_byte;
    job_addr    = addr;
    if (op) begin
      if (cmd == CMD_WRITE) begin
        wel_next = 1'b0;
      end
      phase_next = PH_IDLE;
      cmd_next   = CMD_NONE;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          phase_next = PH_IGNORE;
          if (mosi_byte == OPC_WREN) begin
            wel_next = 1'b1;
          end else if (mosi_byte == OPC_WRDI) begin
            wel_next = 1'b0;
          end else if (mosi_byte == OPC_READ) begin
            cmd_next   = CMD_READ;
            phase_next = PH_AHI;
          end else if (mosi_byte == OPC_WRITE) begin
            cmd_next   = CMD_WRITE;
            phase_next = PH_AHI;
          end
        end
        PH_AHI: begin
          hi_mod_next = HI_TAB[mosi_byte];
          phase_next  = PH_ALO;
        end
        PH_ALO: begin
          addr_next  = (addr_sum >= DEPTH_EXT) ? ADDR_W'(addr_sum - DEPTH_EXT)
                                               : ADDR_W'(addr_sum);
          phase_next = PH_DATA;
        end
        PH_DATA: begin
          if (cmd == CMD_READ) begin
            job.kind = JOB_READ;
          end else if (cmd == CMD_WRITE && wel) begin
            job.kind = JOB_WRITE;
          end
          addr_next = (addr == ADDR_LAST) ? '0 : addr + 1'b1;
        end
        default: begin
          phase_next = PH_IGNORE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      cmd    <= CMD_NONE;
      addr   <= '0;
      hi_mod <= '0;
      wel    <= 1'b0;
    end else if (accept) begin
      phase  <= phase_next;
      cmd    <= cmd_next;
      addr   <= addr_next;
      hi_mod <= hi_mod_next;
      wel    <= wel_next;
    end
  end

endmodule

>>> hdl/sfs_queue.sv
// ----------------------------------------------------------------------------
// sfs_queue
// Two-entry job queue between decoder and memory engine.
// ----------------------------------------------------------------------------
module sfs_queue #(
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sfs_pkg::job_t     push_job,
  input  logic [ADDR_W-1:0] push_addr,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output sfs_pkg::job_t     pop_job,
  output logic [ADDR_W-1:0] pop_addr
);
  import sfs_pkg::*;

  job_t              q_job  [2];
  logic [ADDR_W-1:0] q_addr [2];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_job   = q_job[rd_ptr];
  assign pop_addr  = q_addr[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_job[wr_ptr]  <= push_job;
      q_addr[wr_ptr] <= push_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> hdl/sfs_back.sv
// ----------------------------------------------------------------------------
// sfs_back
// Memory engine: one job per cycle against the single-port byte array,
// registered read data, one result strobe per job.
// ----------------------------------------------------------------------------
module sfs_back #(
  parameter int MEM_DEPTH = 8192,
  parameter int ADDR_W    = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              run,
  input  sfs_pkg::job_t     job,
  input  logic [ADDR_W-1:0] job_addr,
  output logic              done,
  output logic [7:0]        miso_byte,
  output logic              miso_valid
);
  import sfs_pkg::*;

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rdata;

  always_ff @(posedge clk) begin
    if (run && job.kind == JOB_WRITE) begin
      mem[job_addr] <= job.data;
    end
    if (run && job.kind == JOB_READ) begin
      rdata <= mem[job_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      miso_valid <= 1'b0;
    end else begin
      done       <= run;
      miso_valid <= run && (job.kind == JOB_READ);
    end
  end

  assign miso_byte = miso_valid ? rdata : 8'd0;

endmodule

>>> hdl/spi_serial_fram_slave_top.sv
// ----------------------------------------------------------------------------
// spi_serial_fram_slave_top
// Byte-level model of a 25-series SPI serial memory slave.
// ----------------------------------------------------------------------------
// Each word is one SPI byte exchanged while selected (op = 0) or a deselect
// (op = 1). A word is taken on a clock edge with start high and busy low, and
// exactly one result comes back for it: done pulses for one cycle, registered
// behind the queue entry, with miso_byte/miso_valid beside it. Results are
// never held back, so the receiver must take every done pulse. Throughput is
// one word per cycle: the decoder handles a word in the cycle it arrives and
// the memory engine drains one job a cycle through its single memory port, so
// the two-entry queue between them never fills and busy stays low outside of
// reset. miso_byte is zero unless miso_valid flags read data. The array
// powers up undefined; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module spi_serial_fram_slave_top #(
  parameter int MEM_DEPTH = 8192
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       op,
  input  logic [7:0] mosi_byte,
  output logic       done,
  output logic [7:0] miso_byte,
  output logic       miso_valid
);
  import sfs_pkg::*;

  localparam int ADDR_W = $clog2(MEM_DEPTH);

  logic              accept;
  logic              q_full;
  logic              q_not_empty;
  job_t              fe_job;
  logic [ADDR_W-1:0] fe_addr;
  job_t              be_job;
  logic [ADDR_W-1:0] be_addr;

  // busy during reset too, so nothing is taken while state is clearing
  assign busy   = q_full || rst;
  assign accept = start && !busy;

  // front: frame decode, latch and address tracking
  sfs_front #(
    .MEM_DEPTH (MEM_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .mosi_byte (mosi_byte),
    .job       (fe_job),
    .job_addr  (fe_addr)
  );

  sfs_queue #(
    .ADDR_W (ADDR_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_job  (fe_job),
    .push_addr (fe_addr),
    .pop       (q_not_empty),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_job   (be_job),
    .pop_addr  (be_addr)
  );

  // back: memory access and result strobe; drains whenever a job is queued
  sfs_back #(
    .MEM_DEPTH (MEM_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .run        (q_not_empty),
    .job        (be_job),
    .job_addr   (be_addr),
    .done       (done),
    .miso_byte  (miso_byte),
    .miso_valid (miso_valid)
  );

endmodule

>>> hdl/sfs_checker.sv
// ----------------------------------------------------------------------------
// sfs_checker
// Port-level checks on the slave: result timing and read-data flagging.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [7:0] miso_byte,
  input logic       miso_valid
);

  // read data only rides on a result strobe
  `SFS_ASSERT_NOW(a_valid_has_done, miso_valid, done)
  // no read data means a zero byte
  `SFS_ASSERT_NOW(a_idle_byte_zero, !miso_valid, miso_byte == 8'd0)
  // every accepted word yields a result
  `SFS_ASSERT_NOW(a_accept_done, start && !busy, ##2 done)
  // a pending result always lands
  `SFS_ASSERT_NEXT(a_accept_pipe, start && !busy, ##1 done)

endmodule

bind spi_serial_fram_slave_top sfs_checker u_sfs_checker (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial FRAM slave: directed frames, then random
// frame traffic under three sender idle profiles, checked against a local
// byte-level model of the device.
// ----------------------------------------------------------------------------
module tb_top;
  import sfs_pkg::*;

  localparam int MEM_WORDS = 8192;
  localparam int ADDR_W    = 13;

  // op field values
  localparam logic OP_BYTE     = 1'b0;
  localparam logic OP_DESELECT = 1'b1;

  typedef enum logic [2:0] {
    FR_IDLE, FR_ADDR_HI, FR_ADDR_LO, FR_DATA, FR_SKIP
  } frame_phase_e;

  typedef struct packed {
    logic [7:0] miso;
    logic       valid;
  } fram_reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       op = 1'b0;
  logic [7:0] mosi_byte = 8'h00;
  logic       busy;
  logic       done;
  logic [7:0] miso_byte;
  logic       miso_valid;

  spi_serial_fram_slave_top #(
    .MEM_DEPTH(MEM_WORDS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .mosi_byte (mosi_byte),
    .done      (done),
    .miso_byte (miso_byte),
    .miso_valid(miso_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Device shadow: memory image, frame decoder state, write-enable latch.
  // mem_known marks bytes that have really been stored; reads are only ever
  // aimed at those, since the array powers up undefined.
  // --------------------------------------------------------------------------
  logic [7:0]        fram_mem  [0:MEM_WORDS-1];
  bit                mem_known [0:MEM_WORDS-1];
  logic [ADDR_W-1:0] known_addrs[$];
  frame_phase_e      phase    = FR_IDLE;
  logic [1:0]        cur_cmd  = JOB_NONE;
  logic [ADDR_W-1:0] cur_addr = '0;
  logic [7:0]        addr_hi  = 8'h00;
  logic              wel      = 1'b0;

  fram_reply_t reply_q[$];   // expected results, oldest first
  int          mismatches = 0;
  int          words_sent = 0;  // words the device acts on (skipped bytes excluded)
  int          sender_idle_pct = 0;

  // One word through the shadow device; returns the byte it shifts out.
  function automatic fram_reply_t predict_word(input logic is_desel, input logic [7:0] b);
    fram_reply_t rep;
    logic [15:0] full_addr;
    rep = '0;
    if (is_desel == OP_DESELECT) begin
      // ending a WRITE frame drops the latch
      if (cur_cmd == JOB_WRITE) wel = 1'b0;
      phase   = FR_IDLE;
      cur_cmd = JOB_NONE;
    end else begin
      case (phase)
        FR_IDLE: begin
          phase = FR_ADDR_HI;
          if (b == OPC_WREN) begin
            wel   = 1'b1;
            phase = FR_SKIP;
          end else if (b == OPC_WRDI) begin
            wel   = 1'b0;
            phase = FR_SKIP;
          end else if (b == OPC_READ) begin
            cur_cmd = JOB_READ;
          end else if (b == OPC_WRITE) begin
            cur_cmd = JOB_WRITE;
          end else begin
            phase = FR_SKIP;  // unknown opcode: rest of frame ignored
          end
        end
        FR_ADDR_HI: begin
          addr_hi = b;
          phase   = FR_ADDR_LO;
        end
        FR_ADDR_LO: begin
          full_addr = {addr_hi, b};
          cur_addr  = full_addr[ADDR_W-1:0];  // high bits beyond depth dropped
          phase     = FR_DATA;
        end
        FR_DATA: begin
          if (cur_cmd == JOB_READ) begin
            rep.miso  = fram_mem[cur_addr];
            rep.valid = 1'b1;
          end else if (cur_cmd == JOB_WRITE && wel) begin
            fram_mem[cur_addr]  = b;
            mem_known[cur_addr] = 1'b1;
            known_addrs.push_back(cur_addr);
          end
          cur_addr = cur_addr + 1'b1;  // wraps at depth
        end
        default: phase = FR_SKIP;
      endcase
    end
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Send one word. Called right after a rising edge; start stays high on
  // return so back-to-back words need no low cycle. Each cycle before the
  // word idles with the profile's chance.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic w_op, input logic [7:0] w_byte);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    op        <= w_op;
    mosi_byte <= w_byte;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (!(w_op == OP_BYTE && phase == FR_SKIP)) words_sent++;
    reply_q.push_back(predict_word(w_op, w_byte));
  endtask

  // high byte carries random bits above the device depth
  task automatic send_addr(input logic [ADDR_W-1:0] a);
    send_word(OP_BYTE, {3'($urandom_range(0, 7)), a[12:8]});
    send_word(OP_BYTE, a[7:0]);
  endtask

  task automatic deselect();
    send_word(OP_DESELECT, 8'($urandom_range(0, 255)));
  endtask

  // Mostly a 256-byte window straddling the top of the array, so writes
  // cluster, reads find long written runs and the wrap gets exercised.
  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 3) == 0) return ADDR_W'($urandom_range(0, MEM_WORDS - 1));
    return 13'h1F80 + ADDR_W'($urandom_range(0, 255));
  endfunction

  task automatic write_frame(input bit with_wren);
    int n;
    if (with_wren) begin
      send_word(OP_BYTE, OPC_WREN);
      deselect();
    end
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
    send_word(OP_BYTE, OPC_WRITE);
    send_addr(pick_addr());
    repeat (n) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
    deselect();
  endtask

  // Read only across bytes that hold stored data.
  task automatic read_frame();
    logic [ADDR_W-1:0] a;
    int run;
    if (known_addrs.size() == 0) begin
      write_frame(1'b1);
      return;
    end
    a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
    run = 0;
    while (run < 12 && mem_known[ADDR_W'(a + run)]) run++;
    send_word(OP_BYTE, OPC_READ);
    send_addr(a);
    repeat ($urandom_range(1, run)) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
    deselect();
  endtask

  task automatic random_frame();
    int pick;
    logic [7:0] opc;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      write_frame($urandom_range(0, 4) != 0);
    end else if (pick < 60) begin
      read_frame();
    end else if (pick < 68) begin
      // latch commands, sometimes with trailing bytes
      send_word(OP_BYTE, $urandom_range(0, 1) ? OPC_WREN : OPC_WRDI);
      repeat ($urandom_range(0, 2)) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
      deselect();
    end else if (pick < 78) begin
      do opc = 8'($urandom_range(0, 255));
      while (opc == OPC_WREN || opc == OPC_WRDI || opc == OPC_READ || opc == OPC_WRITE);
      send_word(OP_BYTE, opc);
      repeat ($urandom_range(0, 4)) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
      deselect();
    end else if (pick < 90) begin
      // frame cut off before the data phase
      send_word(OP_BYTE, $urandom_range(0, 1) ? OPC_READ : OPC_WRITE);
      repeat ($urandom_range(0, 2)) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
      deselect();
    end else begin
      repeat ($urandom_range(1, 2)) deselect();
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Deselect with no frame open; WREN whose trailing WRDI byte must be ignored.
  task automatic test_deselect_and_latch();
    send_word(OP_DESELECT, 8'hFF);
    send_word(OP_BYTE, OPC_WREN);
    send_word(OP_BYTE, OPC_WRDI);
    send_word(OP_DESELECT, 8'h00);
  endtask

  // Address 0xFFFE folds to the last two bytes; data runs across the wrap.
  task automatic test_write_wrap();
    send_word(OP_BYTE, OPC_WRITE);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'hFE);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'h80);
    send_word(OP_BYTE, 8'h7F);
    send_word(OP_DESELECT, 8'h00);
  endtask

  // Latch was dropped by the last write frame: this byte must not land.
  task automatic test_write_blocked();
    send_word(OP_BYTE, OPC_WRITE);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hAA);
    send_word(OP_DESELECT, 8'hFF);
  endtask

  // Read back across the wrap; address 0 must still hold the first write.
  task automatic test_read_back();
    send_word(OP_BYTE, OPC_READ);
    send_word(OP_BYTE, 8'h1F);
    send_word(OP_BYTE, 8'hFE);
    repeat (4) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
    send_word(OP_DESELECT, 8'h00);
  endtask

  // WRDI with a READ byte behind it, unknown opcode with a WREN behind it.
  task automatic test_ignored_frames();
    send_word(OP_BYTE, OPC_WRDI);
    send_word(OP_BYTE, OPC_READ);
    send_word(OP_DESELECT, 8'hFF);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, OPC_WREN);
    send_word(OP_DESELECT, 8'h00);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int n_words);
    int goal;
    sender_idle_pct = idle_pct;
    goal = words_sent + n_words;
    while (words_sent < goal) random_frame();
  endtask

  // --------------------------------------------------------------------------
  // Result check: done is a one-cycle strobe, compared against the oldest
  // expectation. Sampled on the edge, so values are the pre-edge ones.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    fram_reply_t want;
    if (!rst && done === 1'b1) begin
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: miso_byte=%02h miso_valid=%b", miso_byte, miso_valid);
      end else begin
        want = reply_q.pop_front();
        if (miso_byte !== want.miso || miso_valid !== want.valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: miso_byte exp %02h got %02h, miso_valid exp %b got %b",
                     want.miso, miso_byte, want.valid, miso_valid);
        end
      end
    end
  end

  initial begin : run_tests
    int drain;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_deselect_and_latch();
    test_write_wrap();
    test_write_blocked();
    test_read_back();
    test_ignored_frames();

    // sender idle profiles: light, heavy, none
    test_random_traffic(32, 520);
    test_random_traffic(67, 520);
    test_random_traffic(0, 510);
    start <= 1'b0;

    drain = 0;
    while (reply_q.size() != 0 && drain < 1000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);  // catch any stray strobe

    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
